// ===== rtl/dgf_pkg.sv =====
`default_nettype none

package dgf_pkg;

  // Field widths
  localparam int JAC_W  = 16;
  localparam int QW_W   = 16;
  localparam int PROD_W = 32;
  localparam int DET_W  = 33;
  localparam int SUM_W  = 32;
  localparam int NUM_W  = 49;
  localparam int DEN_W  = 32;
  localparam int RES_W  = 32;

  // Divider layout: quotient bits resolved per stage and stage counts
  localparam int QUO_W     = 32;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STG   = QUO_W / DIV_STEPS;
  localparam int LANE_STG  = DIV_STG + 2;
  localparam int PRE_STG   = 3;
  localparam int NSTG      = PRE_STG + LANE_STG;

  // Saturation bounds of a Q16.16 result
  localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

  // Per-lane tag carried through the divider
  typedef struct packed {
    logic zero;
    logic neg;
  } dgf_tag_t;

  // Per-item sideband carried through the whole pipeline
  typedef struct packed {
    logic last;
    logic sing;
  } dgf_side_t;

endpackage

`default_nettype wire

// ===== rtl/diffusion_geometric_factor_2d.sv =====
`default_nettype none

// Channel   Handshake                Payload
// in_       in_valid / in_ready      jac_11, jac_21, jac_12, jac_22, quad_weight, last_point
// out_      out_valid / out_ready    geo_xx, geo_xy, geo_yy, singular, clipped, last_out
//
// One quadrature point enters per cycle while in_ready is high; each passes to
// out_valid through 13 register stages: products, sums, weight scaling, divider setup
// with rounding, eight divider stages of four quotient bits each, then sign and saturation.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stage holds while its successor is full and cannot move, and empty stages close
// up, so input is still taken while a result waits at the output.

module diffusion_geometric_factor_2d import dgf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [JAC_W-1:0] in_jac_11,
  input  logic signed [JAC_W-1:0] in_jac_21,
  input  logic signed [JAC_W-1:0] in_jac_12,
  input  logic signed [JAC_W-1:0] in_jac_22,
  input  logic [QW_W-1:0]         in_quad_weight,
  input  logic                    in_last_point,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RES_W-1:0] out_geo_xx,
  output logic signed [RES_W-1:0] out_geo_xy,
  output logic signed [RES_W-1:0] out_geo_yy,
  output logic                    out_singular,
  output logic                    out_clipped,
  output logic                    out_last_out
);

  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG:0]   rdy;
  dgf_side_t       side_r [NSTG];

  // Ready ripples back; a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    if (rdy[0]) begin
      valid_nxt[0] = in_valid;
    end else begin
      valid_nxt[0] = valid_r[0];
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Stage 0: all Jacobian products
  logic signed [PROD_W-1:0] p_11_22_r, p_21_12_r, p_12_12_r, p_22_22_r;
  logic signed [PROD_W-1:0] p_11_12_r, p_21_22_r, p_11_11_r, p_21_21_r;
  logic [QW_W-1:0]          qw0_r, qw1_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_11_22_r   <= in_jac_11 * in_jac_22;
      p_21_12_r   <= in_jac_21 * in_jac_12;
      p_12_12_r   <= in_jac_12 * in_jac_12;
      p_22_22_r   <= in_jac_22 * in_jac_22;
      p_11_12_r   <= in_jac_11 * in_jac_12;
      p_21_22_r   <= in_jac_21 * in_jac_22;
      p_11_11_r   <= in_jac_11 * in_jac_11;
      p_21_21_r   <= in_jac_21 * in_jac_21;
      qw0_r       <= in_quad_weight;
      side_r[0]   <= '{last: in_last_point, sing: 1'b0};
    end
  end

  // Stage 1: determinant and sums of products, with magnitudes
  logic signed [DET_W-1:0] det_nxt, sxy_nxt;
  logic [DEN_W-1:0]        md_nxt, sxy_mag_nxt;
  logic [SUM_W-1:0]        sxx_nxt, syy_nxt;
  logic [DEN_W-1:0]        md1_r, md2_r;
  logic [SUM_W-1:0]        sxx_r, sxy_mag_r, syy_r;
  logic                    det_neg_r, sxy_neg_r, zero1_r;

  always_comb begin
    det_nxt     = {p_11_22_r[PROD_W-1], p_11_22_r} - {p_21_12_r[PROD_W-1], p_21_12_r};
    sxy_nxt     = {p_11_12_r[PROD_W-1], p_11_12_r} + {p_21_22_r[PROD_W-1], p_21_22_r};
    sxx_nxt     = SUM_W'(p_12_12_r) + SUM_W'(p_22_22_r);
    syy_nxt     = SUM_W'(p_11_11_r) + SUM_W'(p_21_21_r);
    md_nxt      = det_nxt[DET_W-1] ? DEN_W'(-det_nxt) : DEN_W'(det_nxt);
    sxy_mag_nxt = sxy_nxt[DET_W-1] ? DEN_W'(-sxy_nxt) : DEN_W'(sxy_nxt);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      md1_r     <= md_nxt;
      det_neg_r <= det_nxt[DET_W-1];
      zero1_r   <= (det_nxt == '0);
      sxx_r     <= sxx_nxt;
      syy_r     <= syy_nxt;
      sxy_mag_r <= sxy_mag_nxt;
      sxy_neg_r <= sxy_nxt[DET_W-1];
      qw1_r     <= qw0_r;
      side_r[1] <= '{last: side_r[0].last, sing: (det_nxt == '0)};
    end
  end

  // Stage 2: scale by twice the weight and settle each quotient's sign
  logic [NUM_W-1:0] mn_xx_r, mn_xy_r, mn_yy_r;
  dgf_tag_t         tag_xx_r, tag_xy_r, tag_yy_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      mn_xx_r   <= {(NUM_W-1)'(qw1_r) * (NUM_W-1)'(sxx_r), 1'b0};
      mn_xy_r   <= {(NUM_W-1)'(qw1_r) * (NUM_W-1)'(sxy_mag_r), 1'b0};
      mn_yy_r   <= {(NUM_W-1)'(qw1_r) * (NUM_W-1)'(syy_r), 1'b0};
      md2_r     <= md1_r;
      tag_xx_r  <= '{zero: zero1_r, neg: det_neg_r};
      tag_xy_r  <= '{zero: zero1_r, neg: !sxy_neg_r ^ det_neg_r};
      tag_yy_r  <= '{zero: zero1_r, neg: det_neg_r};
      side_r[2] <= side_r[1];
    end
  end

  // Hold sideband alongside the divider stages
  for (genvar k = PRE_STG; k < NSTG; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic [RES_W-1:0] res_xx, res_xy, res_yy;
  logic             clip_xx, clip_xy, clip_yy;

  dgf_rdiv u_div_xx (
    .clk    (clk),
    .en     (rdy[NSTG-1:PRE_STG]),
    .mn_i   (mn_xx_r),
    .md_i   (md2_r),
    .tag_i  (tag_xx_r),
    .res_o  (res_xx),
    .clip_o (clip_xx)
  );

  dgf_rdiv u_div_xy (
    .clk    (clk),
    .en     (rdy[NSTG-1:PRE_STG]),
    .mn_i   (mn_xy_r),
    .md_i   (md2_r),
    .tag_i  (tag_xy_r),
    .res_o  (res_xy),
    .clip_o (clip_xy)
  );

  dgf_rdiv u_div_yy (
    .clk    (clk),
    .en     (rdy[NSTG-1:PRE_STG]),
    .mn_i   (mn_yy_r),
    .md_i   (md2_r),
    .tag_i  (tag_yy_r),
    .res_o  (res_yy),
    .clip_o (clip_yy)
  );

  // Drive the result channel from the last stage
  assign in_ready     = rdy[0];
  assign out_valid    = valid_r[NSTG-1];
  assign out_geo_xx   = $signed(res_xx);
  assign out_geo_xy   = $signed(res_xy);
  assign out_geo_yy   = $signed(res_yy);
  assign out_singular = side_r[NSTG-1].sing;
  assign out_clipped  = clip_xx | clip_xy | clip_yy;
  assign out_last_out = side_r[NSTG-1].last;

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |->
      out_geo_xx == '0 && out_geo_xy == '0 && out_geo_yy == '0 && !out_clipped)
    else $error("singular result not zero");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&valid_r) && !out_ready |-> !in_ready)
    else $error("input taken into a full stalled pipeline");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r[0])
    else $error("accepted transaction lost at first stage");

  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[PRE_STG] && !rdy[PRE_STG+1] |=> valid_r[PRE_STG])
    else $error("stalled divider stage dropped its transaction");
`endif

endmodule

`default_nettype wire

// ===== rtl/dgf_rdiv.sv =====
`default_nettype none

module dgf_rdiv import dgf_pkg::*; (
  input  logic                clk,
  input  logic [LANE_STG-1:0] en,
  input  logic [NUM_W-1:0]    mn_i,
  input  logic [DEN_W-1:0]    md_i,
  input  dgf_tag_t            tag_i,
  output logic [RES_W-1:0]    res_o,
  output logic                clip_o
);

  // Stage registers, index 0 is the setup stage
  logic [DEN_W:0]   rem_r [DIV_STG+1];
  logic [DEN_W:0]   den_r [DIV_STG+1];
  logic [QUO_W-1:0] lo_r  [DIV_STG+1];
  logic [QUO_W-1:0] quo_r [DIV_STG+1];
  logic             ovf_r [DIV_STG+1];
  dgf_tag_t         tag_r [DIV_STG+1];

  logic [NUM_W:0]   a_nxt;
  logic [DEN_W:0]   d_nxt;
  logic [DEN_W:0]   rem_nxt;
  logic             ovf_nxt;

  // Set up rounded dividend 2|n|+|d| over divisor 2|d|, catch quotients of 2^32 or more
  always_comb begin
    a_nxt   = {mn_i, 1'b0} + {{(NUM_W+1-DEN_W){1'b0}}, md_i};
    d_nxt   = {md_i, 1'b0};
    rem_nxt = {{(DEN_W+1-(NUM_W+1-QUO_W)){1'b0}}, a_nxt[NUM_W:QUO_W]};
    ovf_nxt = (rem_nxt >= d_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= rem_nxt;
      den_r[0] <= d_nxt;
      lo_r[0]  <= a_nxt[QUO_W-1:0];
      quo_r[0] <= '0;
      ovf_r[0] <= ovf_nxt;
      tag_r[0] <= tag_i;
    end
  end

  // Restoring division, DIV_STEPS quotient bits per stage
  for (genvar s = 0; s < DIV_STG; s++) begin : g_div
    logic [DEN_W:0]   rem_c;
    logic [QUO_W-1:0] lo_c;
    logic [QUO_W-1:0] quo_c;

    always_comb begin
      logic [DEN_W+1:0] t;
      rem_c = rem_r[s];
      lo_c  = lo_r[s];
      quo_c = quo_r[s];
      t     = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        t    = {rem_c, lo_c[QUO_W-1]};
        lo_c = {lo_c[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, den_r[s]}) begin
          t     = t - {1'b0, den_r[s]};
          quo_c = {quo_c[QUO_W-2:0], 1'b1};
        end else begin
          quo_c = {quo_c[QUO_W-2:0], 1'b0};
        end
        rem_c = t[DEN_W:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s+1]) begin
        rem_r[s+1] <= rem_c;
        den_r[s+1] <= den_r[s];
        lo_r[s+1]  <= lo_c;
        quo_r[s+1] <= quo_c;
        ovf_r[s+1] <= ovf_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  logic [RES_W-1:0] res_nxt;
  logic             clip_nxt;

  // Apply sign, saturate, force zero for a singular Jacobian
  always_comb begin
    res_nxt  = quo_r[DIV_STG];
    clip_nxt = 1'b0;
    if (tag_r[DIV_STG].zero) begin
      res_nxt = '0;
    end else if (ovf_r[DIV_STG]) begin
      clip_nxt = 1'b1;
      res_nxt  = tag_r[DIV_STG].neg ? RES_MIN : RES_MAX;
    end else if (!tag_r[DIV_STG].neg) begin
      if (quo_r[DIV_STG] > RES_MAX) begin
        clip_nxt = 1'b1;
        res_nxt  = RES_MAX;
      end
    end else begin
      if (quo_r[DIV_STG] > RES_MIN) begin
        clip_nxt = 1'b1;
        res_nxt  = RES_MIN;
      end else begin
        res_nxt = '0 - quo_r[DIV_STG];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[LANE_STG-1]) begin
      res_o  <= res_nxt;
      clip_o <= clip_nxt;
    end
  end

endmodule

`default_nettype wire
